// ===== design/poxw_pkg.sv =====
// Shared types and constants for the pulse oximetry window estimator.
package poxw_pkg;

  // Field widths of the input and result words.
  localparam int SAMPLE_W = 16;
  localparam int HR_W     = 23;
  localparam int PEAKS_W  = 5;
  localparam int SPO2_W   = 7;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPDATE_INTERVAL = 2'd0,
    CFG_SAMPLE_RATE     = 2'd1,
    CFG_MIN_PEAK_GAP    = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] UPDATE_INTERVAL_RST = 8'd20;
  localparam logic [9:0] SAMPLE_RATE_RST     = 10'd5;
  localparam logic [9:0] MIN_PEAK_GAP_RST    = 10'd2;

  // Division by nine as a multiply by a rounded-up reciprocal and a shift.
  localparam logic [22:0] SMOOTH_RECIP = 23'd7456541;
  localparam int          SMOOTH_SHIFT = 26;

  // Peak threshold is 11/10 of the mean.
  localparam int PEAK_NUM = 11;
  localparam int PEAK_DEN = 10;

  // Hundredths of a beat per minute per peak interval and sample rate.
  localparam logic [12:0] HR_SCALE = 13'd6000;

  // SpO2 search: candidate percent counts down; multiplier 221-2k starts at 1.
  localparam logic [6:0] SPO2_K_START = 7'd110;
  localparam logic [6:0] SPO2_K_MAX   = 7'd100;

  typedef struct packed {
    logic [SAMPLE_W-1:0] ir_sample;
    logic [SAMPLE_W-1:0] red_sample;
  } in_word_t;

  typedef struct packed {
    logic [HR_W-1:0]    heart_rate_centi;
    logic [PEAKS_W-1:0] peaks_found;
    logic [SPO2_W-1:0]  spo2_percent;
    logic               spo2_valid;
  } out_word_t;

endpackage

// ===== design/poxw_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module poxw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/pulse_oximetry_window_estimator.sv =====
// Top level of the pulse oximetry window estimator: windows, sequencer and arithmetic.
//
//   channel | direction | handshake              | word
//   in      | input     | in_valid_i, in_stall_o   | in_word_i  (IR and red sample)
//   out     | output    | out_valid_o, out_stall_i | out_word_o (rate, peaks, SpO2)
//   cfg     | input     | cfg_we_i, cfg_idx_i      | cfg_data_i
//
// After reset a clearing pass writes zero to every window entry, with the input stalled.
// An update runs three window passes, two products on the shift-add multiplier, the
// SpO2 search and the heart rate divider, one window RAM port per pass. The input is
// stalled for the whole update; a result waiting on out_stall_i does not hold off new
// input words until the following update is ready to leave.
module pulse_oximetry_window_estimator #(
  parameter int WINDOW    = 100,
  parameter int MAX_PEAKS = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  poxw_pkg::in_word_t                 in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output poxw_pkg::out_word_t                out_word_o,
  input  logic                               cfg_we_i,
  input  logic [poxw_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [poxw_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  import poxw_pkg::*;

  localparam int LW   = $clog2(WINDOW);
  localparam int SW   = SAMPLE_W + LW;
  localparam int AW   = SW + LW;
  localparam int PRW  = AW + SW;
  localparam int N50W = PRW + 6;
  localparam int ACCW = PRW + 8;
  localparam int CMPW = SAMPLE_W + 4 + LW;
  localparam int GW   = (LW > CFG_DATA_W) ? LW : CFG_DATA_W;
  localparam int PCW  = $clog2(MAX_PEAKS + 1);
  localparam int HNW  = HR_W + PCW;
  localparam int MCW  = $clog2(SW + 1);
  localparam int DCW  = $clog2(HNW + 1);

  localparam logic [LW:0]      WIN_CNT  = (LW + 1)'(WINDOW);
  localparam logic [LW-1:0]    LAST_IDX = LW'(WINDOW - 1);
  localparam logic [SW-1:0]    WIN_SW   = SW'(WINDOW);
  localparam logic [CMPW-1:0]  PK_SCALE = CMPW'(PEAK_DEN * WINDOW);
  localparam logic [CMPW-1:0]  PK_MUL   = CMPW'(PEAK_NUM);
  localparam logic [PCW-1:0]   MAXP     = PCW'(MAX_PEAKS);
  localparam logic [MCW-1:0]   MUL_LAST = MCW'(SW - 1);
  localparam logic [DCW-1:0]   DIV_LAST = DCW'(HNW - 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SMOOTH, ST_SUM, ST_SCAN, ST_MUL_NUM, ST_MUL_DEN,
    ST_SPO2_PREP, ST_SPO2, ST_HR_SCALE, ST_HR_MUL, ST_HR_DIV, ST_DONE
  } state_e;

  state_e state_q;

  // Configuration and sample counting.
  logic [7:0]  upd_int_q;
  logic [9:0]  rate_q;
  logic [9:0]  gap_q;
  logic [7:0]  cnt_q;
  logic [7:0]  cnt_inc;

  // Circular window addressing and pass pipeline.
  logic [LW-1:0] head_q;
  logic [LW:0]   rd_cnt_q;
  logic          dv_q;
  logic [LW-1:0] dj_q;

  // Smoothing taps, sums, peaks and deviations.
  logic [SAMPLE_W-1:0] sq0_q, sq1_q, sq2_q, sq3_q;
  logic [SAMPLE_W-1:0] pk0_q, pk1_q;
  logic [SW-1:0]       s_ir_q, s_red_q;
  logic [CMPW-1:0]     thr_q;
  logic [AW-1:0]       a_ir_q, a_red_q;
  logic [PCW-1:0]      n_q;
  logic [LW-1:0]       first_q, last_q;
  logic                stop_q;

  // Shared shift-add multiplier.
  logic [PRW-1:0] mcand_q, prod_q, num_q, den_q;
  logic [SW-1:0]  mplier_q;
  logic [MCW-1:0] mcnt_q;

  // SpO2 search.
  logic [N50W-1:0] num50_q;
  logic [ACCW-1:0] acc_q;
  logic [6:0]      k_q;
  logic [6:0]      spo2_q;
  logic            spo2_ok_q;

  // Heart rate scaling and divider.
  logic [HR_W-1:0] hr_scale_q;
  logic [HNW-1:0]  div_q;
  logic [LW-1:0]   rem_q, dvs_q;
  logic [DCW-1:0]  dcnt_q;

  logic      out_valid_q;
  out_word_t out_q;

  // RAM ports.
  logic                ir_we, red_we;
  logic [LW-1:0]       ir_wa, red_wa, rd_addr;
  logic [SAMPLE_W-1:0] ir_wd, red_wd, ir_rd, red_rd;

  function automatic logic [LW-1:0] phys(input logic [LW-1:0] base, input logic [LW-1:0] j);
    logic [LW:0] s;
    s = {1'b0, base} + {1'b0, j};
    if (s >= WIN_CNT) s = s - WIN_CNT;
    return s[LW-1:0];
  endfunction

  logic in_acc;
  assign in_acc     = (state_q == ST_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign cnt_inc    = cnt_q + 8'd1;
  assign rd_addr    = phys(head_q, rd_cnt_q[LW-1:0]);

  // Smoothing kernel 1-2-3-2-1 with division by nine.
  logic [19:0]         sm_sum;
  logic [42:0]         sm_prod;
  logic [SAMPLE_W-1:0] sm_new;
  always_comb begin
    sm_sum = 20'(sq0_q) + (20'(sq1_q) << 1) + 20'(sq2_q) + (20'(sq2_q) << 1)
           + (20'(sq3_q) << 1) + 20'(ir_rd);
    sm_prod = 43'(sm_sum) * 43'(SMOOTH_RECIP);
    sm_new  = sm_prod[SMOOTH_SHIFT +: SAMPLE_W];
  end

  // Window RAM write selection.
  always_comb begin
    ir_we  = 1'b0;
    red_we = 1'b0;
    ir_wa  = head_q;
    red_wa = head_q;
    ir_wd  = in_word_i.ir_sample;
    red_wd = in_word_i.red_sample;
    unique case (state_q)
      ST_CLEAR: begin
        ir_we  = 1'b1;
        red_we = 1'b1;
        ir_wa  = rd_cnt_q[LW-1:0];
        red_wa = rd_cnt_q[LW-1:0];
        ir_wd  = '0;
        red_wd = '0;
      end
      ST_IDLE: begin
        ir_we  = in_acc;
        red_we = in_acc;
      end
      ST_SMOOTH: begin
        ir_we = dv_q && (dj_q >= LW'(4));
        ir_wa = phys(head_q, dj_q - LW'(2));
        ir_wd = sm_new;
      end
      default: begin
      end
    endcase
  end

  poxw_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW)) u_ir_ram (
    .clk_i   (clk_i),
    .we_i    (ir_we),
    .waddr_i (ir_wa),
    .wdata_i (ir_wd),
    .raddr_i (rd_addr),
    .rdata_o (ir_rd)
  );

  poxw_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW)) u_red_ram (
    .clk_i   (clk_i),
    .we_i    (red_we),
    .waddr_i (red_wa),
    .wdata_i (red_wd),
    .raddr_i (rd_addr),
    .rdata_o (red_rd)
  );

  // Sums, deviations and peak test on the word arriving from the RAMs.
  logic [SW-1:0]   s_ir_nx, s_red_nx, sc_ir, sc_red, dif_ir, dif_red;
  logic [AW-1:0]   a_ir_nx, a_red_nx;
  logic [CMPW-1:0] pk_lhs;
  logic [LW-1:0]   pk_idx;
  logic            pk_hit, gap_ok, last_data;
  always_comb begin
    s_ir_nx  = s_ir_q + SW'(ir_rd);
    s_red_nx = s_red_q + SW'(red_rd);
    sc_ir    = SW'(ir_rd) * WIN_SW;
    sc_red   = SW'(red_rd) * WIN_SW;
    dif_ir   = (sc_ir >= s_ir_q) ? sc_ir - s_ir_q : s_ir_q - sc_ir;
    dif_red  = (sc_red >= s_red_q) ? sc_red - s_red_q : s_red_q - sc_red;
    a_ir_nx  = a_ir_q + AW'(dif_ir);
    a_red_nx = a_red_q + AW'(dif_red);
    pk_lhs   = CMPW'(pk1_q) * PK_SCALE;
    pk_idx   = dj_q - LW'(1);
    pk_hit   = (dj_q >= LW'(2)) && !stop_q && (pk_lhs > thr_q)
               && (pk1_q > pk0_q) && (pk1_q > ir_rd);
    gap_ok   = (n_q == '0) || (GW'(pk_idx - last_q) > GW'(gap_q));
    last_data = dv_q && (dj_q == LAST_IDX);
  end

  // Multiplier, SpO2 compare and divider steps.
  logic [PRW-1:0] prod_nx;
  logic           spo2_hit;
  logic [LW:0]    dv_trial;
  logic           dv_ge;
  always_comb begin
    prod_nx  = mplier_q[0] ? prod_q + mcand_q : prod_q;
    spo2_hit = (k_q <= SPO2_K_MAX) && (acc_q >= ACCW'(num50_q));
    dv_trial = {rem_q, div_q[HNW-1]};
    dv_ge    = dv_trial >= {1'b0, dvs_q};
  end

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      upd_int_q   <= UPDATE_INTERVAL_RST;
      rate_q      <= SAMPLE_RATE_RST;
      gap_q       <= MIN_PEAK_GAP_RST;
      cnt_q       <= '0;
      head_q      <= '0;
      rd_cnt_q    <= '0;
      dv_q        <= 1'b0;
      dj_q        <= '0;
      n_q         <= '0;
      stop_q      <= 1'b0;
      mcnt_q      <= '0;
      dcnt_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      sq0_q <= '0; sq1_q <= '0; sq2_q <= '0; sq3_q <= '0;
      pk0_q <= '0; pk1_q <= '0;
      s_ir_q <= '0; s_red_q <= '0; thr_q <= '0;
      a_ir_q <= '0; a_red_q <= '0; first_q <= '0; last_q <= '0;
      mcand_q <= '0; prod_q <= '0; num_q <= '0; den_q <= '0; mplier_q <= '0;
      num50_q <= '0; acc_q <= '0; spo2_q <= '0; spo2_ok_q <= 1'b0;
      hr_scale_q <= '0; div_q <= '0; rem_q <= '0; dvs_q <= '0;
      out_q <= '0;
    end else begin
      // Configuration writes.
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_UPDATE_INTERVAL: upd_int_q <= cfg_data_i[7:0];
          CFG_SAMPLE_RATE:     rate_q    <= cfg_data_i;
          CFG_MIN_PEAK_GAP:    gap_q     <= cfg_data_i;
          default: begin
          end
        endcase
      end

      // Result leaves when taken downstream.
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // Window read pipeline for the three passes.
      if (state_q == ST_SMOOTH || state_q == ST_SUM || state_q == ST_SCAN) begin
        dv_q <= (rd_cnt_q < WIN_CNT);
        dj_q <= rd_cnt_q[LW-1:0];
        if (rd_cnt_q < WIN_CNT) rd_cnt_q <= rd_cnt_q + (LW + 1)'(1);
      end

      unique case (state_q)
        ST_CLEAR: begin
          if (rd_cnt_q[LW-1:0] == LAST_IDX) begin
            rd_cnt_q <= '0;
            state_q  <= ST_IDLE;
          end else begin
            rd_cnt_q <= rd_cnt_q + (LW + 1)'(1);
          end
        end

        ST_IDLE: begin
          if (in_acc) begin
            head_q <= (head_q == LAST_IDX) ? '0 : head_q + LW'(1);
            if (cnt_inc < upd_int_q) begin
              cnt_q <= cnt_inc;
            end else begin
              cnt_q    <= '0;
              rd_cnt_q <= '0;
              dv_q     <= 1'b0;
              state_q  <= ST_SMOOTH;
            end
          end
        end

        // Forward in-place smoothing; the newest smoothed value replaces its tap.
        ST_SMOOTH: begin
          if (dv_q) begin
            sq0_q <= sq1_q;
            sq1_q <= (dj_q >= LW'(4)) ? sm_new : sq2_q;
            sq2_q <= sq3_q;
            sq3_q <= ir_rd;
          end
          if (last_data) begin
            rd_cnt_q <= '0;
            dv_q     <= 1'b0;
            s_ir_q   <= '0;
            s_red_q  <= '0;
            state_q  <= ST_SUM;
          end
        end

        ST_SUM: begin
          if (dv_q) begin
            s_ir_q  <= s_ir_nx;
            s_red_q <= s_red_nx;
          end
          if (last_data) begin
            thr_q    <= CMPW'(s_ir_nx) * PK_MUL;
            rd_cnt_q <= '0;
            dv_q     <= 1'b0;
            a_ir_q   <= '0;
            a_red_q  <= '0;
            n_q      <= '0;
            stop_q   <= 1'b0;
            first_q  <= '0;
            last_q   <= '0;
            state_q  <= ST_SCAN;
          end
        end

        // Peak search and absolute deviation sums in one pass.
        ST_SCAN: begin
          if (dv_q) begin
            pk0_q   <= pk1_q;
            pk1_q   <= ir_rd;
            a_ir_q  <= a_ir_nx;
            a_red_q <= a_red_nx;
            if (pk_hit && gap_ok) begin
              if (n_q == '0) first_q <= pk_idx;
              last_q <= pk_idx;
              n_q    <= n_q + PCW'(1);
              if (n_q + PCW'(1) >= MAXP) stop_q <= 1'b1;
            end
          end
          if (last_data) begin
            rd_cnt_q <= '0;
            dv_q     <= 1'b0;
            mcand_q  <= PRW'(a_red_nx);
            mplier_q <= s_ir_q;
            prod_q   <= '0;
            mcnt_q   <= '0;
            state_q  <= ST_MUL_NUM;
          end
        end

        ST_MUL_NUM: begin
          prod_q   <= prod_nx;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          mcnt_q   <= mcnt_q + MCW'(1);
          if (mcnt_q == MUL_LAST) begin
            num_q    <= prod_nx;
            mcand_q  <= PRW'(a_ir_q);
            mplier_q <= s_red_q;
            prod_q   <= '0;
            mcnt_q   <= '0;
            state_q  <= ST_MUL_DEN;
          end
        end

        ST_MUL_DEN: begin
          prod_q   <= prod_nx;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          mcnt_q   <= mcnt_q + MCW'(1);
          if (mcnt_q == MUL_LAST) begin
            den_q   <= prod_nx;
            state_q <= ST_SPO2_PREP;
          end
        end

        ST_SPO2_PREP: begin
          num50_q   <= (N50W'(num_q) << 5) + (N50W'(num_q) << 4) + (N50W'(num_q) << 1);
          acc_q     <= ACCW'(den_q);
          k_q       <= SPO2_K_START;
          spo2_q    <= '0;
          spo2_ok_q <= (den_q != '0);
          state_q   <= (den_q != '0) ? ST_SPO2 : ST_HR_SCALE;
        end

        // Largest percent k with den*(221-2k) >= 50*num.
        ST_SPO2: begin
          priority if (spo2_hit) begin
            spo2_q  <= k_q;
            state_q <= ST_HR_SCALE;
          end else if (k_q == '0) begin
            spo2_q  <= '0;
            state_q <= ST_HR_SCALE;
          end else begin
            k_q   <= k_q - 7'd1;
            acc_q <= acc_q + (ACCW'(den_q) << 1);
          end
        end

        ST_HR_SCALE: begin
          hr_scale_q <= HR_W'(rate_q) * HR_W'(HR_SCALE);
          state_q    <= ST_HR_MUL;
        end

        ST_HR_MUL: begin
          rem_q  <= '0;
          dcnt_q <= '0;
          dvs_q  <= last_q - first_q;
          if (n_q < PCW'(2)) begin
            div_q   <= '0;
            state_q <= ST_DONE;
          end else begin
            div_q   <= HNW'(hr_scale_q) * HNW'(n_q - PCW'(1));
            state_q <= ST_HR_DIV;
          end
        end

        // Restoring division, one quotient bit a cycle.
        ST_HR_DIV: begin
          rem_q  <= dv_ge ? LW'(dv_trial - {1'b0, dvs_q}) : dv_trial[LW-1:0];
          div_q  <= {div_q[HNW-2:0], dv_ge};
          dcnt_q <= dcnt_q + DCW'(1);
          if (dcnt_q == DIV_LAST) state_q <= ST_DONE;
        end

        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.heart_rate_centi <= div_q[HR_W-1:0];
            out_q.peaks_found      <= PEAKS_W'(n_q);
            out_q.spo2_percent     <= spo2_q;
            out_q.spo2_valid       <= spo2_ok_q;
            out_valid_q            <= 1'b1;
            state_q                <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Checks on the sequencer and the result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= MAXP)
    else $error("peak count above limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni) head_q <= LAST_IDX)
    else $error("window head out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.spo2_percent <= SPO2_K_MAX))
    else $error("SpO2 above 100");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.spo2_valid) |-> (out_q.spo2_percent == '0))
    else $error("SpO2 set without valid divisors");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the final step");

endmodule
